[hw/rtl/websocket_frame_deframer_macros.svh]
// assertion macros for the websocket deframer
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// same-cycle implication, checked out of reset
`define WSFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define WSFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/wsfd_pkg.sv]
// types, codes and helper functions for the websocket deframer
package wsfd_pkg;

  typedef enum logic [4:0] {
    PH_HDR0    = 5'b00001,
    PH_HDR1    = 5'b00010,
    PH_EXTLEN  = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_ERROR   = 5'b10000
  } phase_t;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [1:0] ERR_RSV_BITS = 2'd0;
  localparam logic [1:0] ERR_MASKED   = 2'd1;
  localparam logic [1:0] ERR_OPCODE   = 2'd2;

  localparam logic [7:0] FIN_MASK    = 8'h80;
  localparam logic [7:0] RSV_MASK    = 8'h70;
  localparam logic [7:0] MASK_BIT    = 8'h80;
  localparam logic [6:0] LEN_EXT16   = 7'd126;
  localparam logic [6:0] LEN_EXT64   = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  function automatic logic opcode_ok(input logic [3:0] op);
    logic ok;
    case (op)
      OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

[hw/rtl/websocket_frame_deframer.sv]
// websocket receive deframer: header decode and check, length gather, payload pass-through
//
//   channel | direction | payload
//   in_     | input     | rx_byte
//   out_    | output    | item_kind, final_fragment, frame_opcode, frame_length,
//           |           | payload_byte, frame_end, error_code
//
// one word accepted per cycle while in_stall is low, result registered on acceptance
// first header and non-final ext length words give no result; the header word follows them
// rst_n clears the phase and the output valid; after an error all words are dropped
// in_stall is high only while a result is held and out_stall is high
`include "websocket_frame_deframer_macros.svh"

module websocket_frame_deframer
  import wsfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_item_kind,
  output logic        out_final_fragment,
  output logic [3:0]  out_frame_opcode,
  output logic [63:0] out_frame_length,
  output logic [7:0]  out_payload_byte,
  output logic        out_frame_end,
  output logic [1:0]  out_error_code
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  hdr0_r, hdr0_nxt;
  logic [63:0] len_acc_r, len_acc_nxt;
  logic [3:0]  ext_left_r, ext_left_nxt;
  logic [63:0] pay_left_r, pay_left_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic        fin_r, fin_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic [63:0] length_r, length_nxt;
  logic [7:0]  pbyte_r, pbyte_nxt;
  logic        fend_r, fend_nxt;
  logic [1:0]  ecode_r, ecode_nxt;

  logic        accept;
  logic        has_result;
  logic [6:0]  marker;
  logic [63:0] acc_shift;
  logic [3:0]  ext_dec;
  logic [63:0] pay_dec;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign marker    = in_rx_byte[6:0];
  assign acc_shift = {len_acc_r[55:0], in_rx_byte};
  assign ext_dec   = ext_left_r - 4'd1;
  assign pay_dec   = pay_left_r - 64'd1;

  always_comb begin
    phase_nxt    = phase_r;
    hdr0_nxt     = hdr0_r;
    len_acc_nxt  = len_acc_r;
    ext_left_nxt = ext_left_r;
    pay_left_nxt = pay_left_r;
    has_result   = 1'b0;
    kind_nxt     = KIND_HEADER;
    fin_nxt      = 1'b0;
    opcode_nxt   = 4'd0;
    length_nxt   = 64'd0;
    pbyte_nxt    = 8'd0;
    fend_nxt     = 1'b0;
    ecode_nxt    = ERR_RSV_BITS;
    case (phase_r)
      PH_HDR0: begin
        hdr0_nxt  = in_rx_byte;
        phase_nxt = PH_HDR1;
      end
      PH_HDR1: begin
        if ((hdr0_r & RSV_MASK) != 8'd0) begin
          has_result = 1'b1;
          kind_nxt   = KIND_ERROR;
          ecode_nxt  = ERR_RSV_BITS;
          phase_nxt  = PH_ERROR;
        end else if ((in_rx_byte & MASK_BIT) != 8'd0) begin
          has_result = 1'b1;
          kind_nxt   = KIND_ERROR;
          ecode_nxt  = ERR_MASKED;
          phase_nxt  = PH_ERROR;
        end else if (!opcode_ok(hdr0_r[3:0])) begin
          has_result = 1'b1;
          kind_nxt   = KIND_ERROR;
          ecode_nxt  = ERR_OPCODE;
          phase_nxt  = PH_ERROR;
        end else if (marker == LEN_EXT16 || marker == LEN_EXT64) begin
          len_acc_nxt  = 64'd0;
          ext_left_nxt = (marker == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
          phase_nxt    = PH_EXTLEN;
        end else begin
          has_result = 1'b1;
          kind_nxt   = KIND_HEADER;
          fin_nxt    = |(hdr0_r & FIN_MASK);
          opcode_nxt = hdr0_r[3:0];
          length_nxt = {57'd0, marker};
          if (marker == 7'd0) begin
            fend_nxt  = 1'b1;
            phase_nxt = PH_HDR0;
          end else begin
            pay_left_nxt = {57'd0, marker};
            phase_nxt    = PH_PAYLOAD;
          end
        end
      end
      PH_EXTLEN: begin
        len_acc_nxt  = acc_shift;
        ext_left_nxt = ext_dec;
        if (ext_dec == 4'd0) begin
          has_result = 1'b1;
          kind_nxt   = KIND_HEADER;
          fin_nxt    = |(hdr0_r & FIN_MASK);
          opcode_nxt = hdr0_r[3:0];
          length_nxt = acc_shift;
          if (acc_shift == 64'd0) begin
            fend_nxt  = 1'b1;
            phase_nxt = PH_HDR0;
          end else begin
            pay_left_nxt = acc_shift;
            phase_nxt    = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        has_result   = 1'b1;
        kind_nxt     = KIND_PAYLOAD;
        pbyte_nxt    = in_rx_byte;
        pay_left_nxt = pay_dec;
        if (pay_dec == 64'd0) begin
          fend_nxt  = 1'b1;
          phase_nxt = PH_HDR0;
        end
      end
      PH_ERROR: begin
        phase_nxt = PH_ERROR;
      end
      default: begin
        phase_nxt = PH_HDR0;
      end
    endcase
  end

  always_comb begin
    if (accept) begin
      out_valid_nxt = has_result;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR0;
      hdr0_r      <= 8'd0;
      len_acc_r   <= 64'd0;
      ext_left_r  <= 4'd0;
      pay_left_r  <= 64'd0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        phase_r    <= phase_nxt;
        hdr0_r     <= hdr0_nxt;
        len_acc_r  <= len_acc_nxt;
        ext_left_r <= ext_left_nxt;
        pay_left_r <= pay_left_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_result) begin
      kind_r   <= kind_nxt;
      fin_r    <= fin_nxt;
      opcode_r <= opcode_nxt;
      length_r <= length_nxt;
      pbyte_r  <= pbyte_nxt;
      fend_r   <= fend_nxt;
      ecode_r  <= ecode_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_item_kind      = kind_r;
  assign out_final_fragment = fin_r;
  assign out_frame_opcode   = opcode_r;
  assign out_frame_length   = length_r;
  assign out_payload_byte   = pbyte_r;
  assign out_frame_end      = fend_r;
  assign out_error_code     = ecode_r;

  `WSFD_ASSERT_NEXT(a_error_sticky, phase_r == PH_ERROR, phase_r == PH_ERROR, "left error phase")
  `WSFD_ASSERT_NOW(a_error_phase, out_valid_r && kind_r == KIND_ERROR, phase_r == PH_ERROR, "error word outside error phase")
  `WSFD_ASSERT_NOW(a_end_phase, out_valid_r && kind_r == KIND_PAYLOAD && fend_r, phase_r == PH_HDR0, "last payload word without return to header phase")

endmodule
